/* hdl/ohm_pkg.sv */
// Shared constants, lookup functions and control types for the auto-ranging ohmmeter.
// Used by ohm_ctrl, ohm_dp and ohmmeter_autorange_unit; depends on nothing else.
package ohm_pkg;

  // ADC and voltage scaling
  localparam int ADC_BITS  = 8;
  localparam int CODE_W    = 8;
  localparam int MV_W      = 13;
  localparam int FULL_MV   = 5000;
  localparam int FS        = (1 << ADC_BITS) - 1;
  localparam int X_W       = ADC_BITS + MV_W;
  // 1/FS is approximated by (2^B + 1) / 2^(2B); the estimate is at most one low
  localparam int RECIP     = (1 << ADC_BITS) + 1;
  localparam int RECIP_W   = ADC_BITS + 1;
  localparam int EST_W     = X_W + RECIP_W;
  localparam int EST_SHIFT = 2 * ADC_BITS;

  // Resistance arithmetic
  localparam int RREF_W = 24;
  localparam int PROD_W = MV_W + RREF_W;
  localparam int NUM_W  = 36;
  localparam int Q_W    = 16;
  localparam int HI_W   = NUM_W - Q_W;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int RNG_W  = 3;
  localparam int UNIT_W = 2;

  localparam logic [MV_W-1:0] OPEN_MV_RESET = MV_W'(4500);

  typedef enum logic [UNIT_W-1:0] {
    UNIT_OHM  = 2'd0,
    UNIT_KOHM = 2'd1,
    UNIT_MOHM = 2'd2
  } unit_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic est;
    logic fix;
    logic check;
    logic pre;
    logic div_step;
    logic commit;
  } ohm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic need_div;
  } ohm_sts_t;

  // Numerator factor per range; the 50 ohm range carries the x3.7 scale (50 * 3.7 = 185)
  function automatic logic [RREF_W-1:0] rref_factor(input logic [RNG_W-1:0] r);
    logic [RREF_W-1:0] f;
    case (r)
      3'd0:    f = RREF_W'(185);
      3'd1:    f = RREF_W'(100);
      3'd2:    f = RREF_W'(1000);
      3'd3:    f = RREF_W'(10000);
      3'd4:    f = RREF_W'(100000);
      3'd5:    f = RREF_W'(1000000);
      3'd6:    f = RREF_W'(5000000);
      3'd7:    f = RREF_W'(10000000);
      default: f = RREF_W'(185);
    endcase
    return f;
  endfunction

  // Inclusive lower bound of each range window in mV
  function automatic logic [MV_W-1:0] win_lo(input logic [RNG_W-1:0] r);
    logic [MV_W-1:0] v;
    case (r)
      3'd0:    v = MV_W'(100);
      3'd1:    v = MV_W'(2450);
      default: v = MV_W'(2400);
    endcase
    return v;
  endfunction

  // Exclusive upper bound of each range window in mV; the top range window is empty
  function automatic logic [MV_W-1:0] win_hi(input logic [RNG_W-1:0] r);
    logic [MV_W-1:0] v;
    case (r)
      3'd0:    v = MV_W'(3323);
      3'd1:    v = MV_W'(4500);
      3'd2:    v = MV_W'(4500);
      3'd3:    v = MV_W'(4500);
      3'd4:    v = MV_W'(4500);
      3'd5:    v = MV_W'(4167);
      3'd6:    v = MV_W'(3333);
      3'd7:    v = MV_W'(1666);
      default: v = MV_W'(1666);
    endcase
    return v;
  endfunction

  // Unit label of each range
  function automatic unit_t unit_of(input logic [RNG_W-1:0] r);
    unit_t u;
    case (r)
      3'd0, 3'd1:       u = UNIT_OHM;
      3'd2, 3'd3, 3'd4: u = UNIT_KOHM;
      default:          u = UNIT_MOHM;
    endcase
    return u;
  endfunction

endpackage

/* hdl/ohm_ctrl.sv */
// Sequencing state machine of the auto-ranging ohmmeter.
// Depends on ohm_pkg; drives ohm_dp through ohm_cmd_t and reads ohm_sts_t.
module ohm_ctrl import ohm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ohm_sts_t sts,
  output ohm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EST,
    S_FIX,
    S_CHECK,
    S_PRE,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and divider step count
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EST;
      S_EST:   state_nxt = S_FIX;
      S_FIX:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_PRE;
      S_PRE:   state_nxt = S_DIV;
      S_DIV: begin
        if (!sts.need_div) begin
          state_nxt = S_DONE;
          cnt_nxt   = '0;
        end else if (cnt_r == CNT_W'(Q_W - 1)) begin
          state_nxt = S_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Decode commands from state
  assign in_stall     = (state_r != S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && in_valid;
  assign cmd.est      = (state_r == S_EST);
  assign cmd.fix      = (state_r == S_FIX);
  assign cmd.check    = (state_r == S_CHECK);
  assign cmd.pre      = (state_r == S_PRE);
  assign cmd.div_step = (state_r == S_DIV) && sts.need_div;
  assign cmd.commit   = (state_r == S_DONE) && sts.out_free;

  // A division past its first step only runs for an in-window, unsaturated reading
  a_div_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != '0) |-> sts.need_div)
    else $error("divider running without a pending quotient");

endmodule

/* hdl/ohm_dp.sv */
// Datapath of the auto-ranging ohmmeter: mV scaling, window check, serial divider,
// range register, threshold register and output register. Depends on ohm_pkg.
module ohm_dp import ohm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ohm_cmd_t          cmd,
  output ohm_sts_t          sts,
  input  logic [CODE_W-1:0] in_adc_code,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MV_W-1:0]   cfg_open_threshold_mv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_open_circuit,
  output logic              out_reading_valid,
  output logic [Q_W-1:0]    out_reading,
  output logic [UNIT_W-1:0] out_unit_code,
  output logic [RNG_W-1:0]  out_range_select
);

  logic [MV_W-1:0]   thr_r;
  logic [RNG_W-1:0]  range_r, range_nxt;
  logic [X_W-1:0]    x_r;
  logic [MV_W-1:0]   qe_r;
  logic [MV_W-1:0]   v_r;
  logic              open_r;
  logic              hit_r;
  logic              sat_r;
  logic [NUM_W-1:0]  num_r;
  logic [MV_W-1:0]   dvs_r;
  logic [MV_W-1:0]   rem_r;
  logic [Q_W-1:0]    quo_r;

  logic              out_valid_r;
  logic              out_open_r;
  logic              out_rv_r;
  logic [Q_W-1:0]    out_reading_r;
  logic [UNIT_W-1:0] out_unit_r;
  logic [RNG_W-1:0]  out_range_r;

  logic [X_W-1:0]    x_nxt;
  logic [EST_W-1:0]  est_prod;
  logic [X_W-1:0]    back_prod;
  logic [X_W-1:0]    resid;
  logic [MV_W-1:0]   v_nxt;
  logic              open_nxt;
  logic              hit_nxt;
  logic [PROD_W-1:0] num_prod;
  logic [HI_W-1:0]   num_hi;
  logic [MV_W:0]     trial;
  logic              trial_ge;
  logic [Q_W-1:0]    reading_nxt;
  logic [UNIT_W-1:0] unit_nxt;
  logic              take_out;

  // Scale the sample: x = code * 5000
  assign x_nxt = X_W'(in_adc_code[ADC_BITS-1:0]) * X_W'(FULL_MV);

  // Estimate x / FS by reciprocal, then correct with one compare
  assign est_prod  = EST_W'(x_r) * EST_W'(RECIP);
  assign back_prod = X_W'(qe_r) * X_W'(FS);
  assign resid     = x_r - back_prod;
  assign v_nxt     = (resid >= X_W'(FS)) ? qe_r + MV_W'(1) : qe_r;

  // Classify against threshold and the current range window
  assign open_nxt = (v_r > thr_r);
  assign hit_nxt  = !open_nxt && (v_r >= win_lo(range_r)) && (v_r < win_hi(range_r))
                    && (v_r < MV_W'(FULL_MV));
  assign num_prod = PROD_W'(v_r) * PROD_W'(rref_factor(range_r));

  // Restoring division step: one quotient bit per cycle
  assign num_hi   = num_r[NUM_W-1:Q_W];
  assign trial    = {rem_r, quo_r[Q_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});

  // Result fields and range update
  assign reading_nxt = hit_r ? (sat_r ? {Q_W{1'b1}} : quo_r) : '0;
  assign unit_nxt    = hit_r ? UNIT_W'(unit_of(range_r)) : '0;
  assign range_nxt   = (!open_r && !hit_r) ? range_r + RNG_W'(1) : range_r;

  assign take_out     = out_valid_r && !out_stall;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.need_div = hit_r && !sat_r;

  // Working registers of one measurement
  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= x_nxt;
    if (cmd.est)  qe_r <= est_prod[EST_SHIFT +: MV_W];
    if (cmd.fix)  v_r <= v_nxt;
    if (cmd.check) begin
      open_r <= open_nxt;
      hit_r  <= hit_nxt;
      num_r  <= NUM_W'(num_prod);
      dvs_r  <= MV_W'(FULL_MV) - v_r;
    end
    if (cmd.pre) begin
      sat_r <= (num_hi >= HI_W'(dvs_r));
      rem_r <= MV_W'(num_hi);
      quo_r <= num_r[Q_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? MV_W'(trial - {1'b0, dvs_r}) : MV_W'(trial);
      quo_r <= {quo_r[Q_W-2:0], trial_ge};
    end
  end

  // Threshold and range state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= OPEN_MV_RESET;
      range_r <= '0;
    end else begin
      if (cfg_valid) thr_r <= cfg_open_threshold_mv;
      if (cmd.commit) range_r <= range_nxt;
    end
  end

  // Output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (take_out) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_open_r    <= open_r;
      out_rv_r      <= hit_r;
      out_reading_r <= reading_nxt;
      out_unit_r    <= unit_nxt;
      out_range_r   <= range_nxt;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_open_circuit  = out_open_r;
  assign out_reading_valid = out_rv_r;
  assign out_reading       = out_reading_r;
  assign out_unit_code     = out_unit_r;
  assign out_range_select  = out_range_r;

  a_not_open_and_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_open_r && out_rv_r))
    else $error("open circuit and valid reading reported together");

  a_range_held: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !cmd.commit) |=> $stable(range_r))
    else $error("range changed outside a commit");

  a_mv_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check |-> (v_r <= MV_W'(FULL_MV)))
    else $error("scaled voltage above full scale");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule

/* hdl/ohmmeter_autorange_unit.sv */
// Top level of the auto-ranging ohmmeter: controller plus datapath.
// Depends on ohm_pkg, ohm_ctrl and ohm_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_adc_code): one ADC sample of the
//   divider voltage per transaction. Every sample yields exactly one result.
//   Result channel (out_valid / out_stall / out_*): open-circuit flag, reading
//   valid flag, 16-bit resistance in ohms, unit label and the range select to
//   apply to the reference mux after this sample.
//   Configuration (cfg_valid / cfg_ready / cfg_open_threshold_mv): writes the
//   open-circuit threshold in mV; cfg_ready is always high.
// Sequence:
//   A sample taken in-window runs scaling and classification (states EST, FIX,
//   CHECK and PRE) and a 16-step serial divider (state DIV); the result is
//   committed in DONE, and the next sample is taken only back in IDLE.
//   Samples that are open, out of window or saturated skip the divider steps:
//   they leave DIV without a step and go straight to DONE.
//   While out_stall is low, the divider's one bit per cycle sets the rate.
// Reset (rst_n low, synchronous): range goes to the 50 ohm range, threshold
//   to 4500 mV, the output register empties.
// Stall: a result waits in the output register while out_stall is high; the
//   next sample is still accepted and computed, and held until the slot frees.
module ohmmeter_autorange_unit import ohm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] in_adc_code,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MV_W-1:0]   cfg_open_threshold_mv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_open_circuit,
  output logic              out_reading_valid,
  output logic [Q_W-1:0]    out_reading,
  output logic [UNIT_W-1:0] out_unit_code,
  output logic [RNG_W-1:0]  out_range_select
);

  ohm_cmd_t cmd;
  ohm_sts_t sts;

  // Sequencer
  ohm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, range state and output register
  ohm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_adc_code           (in_adc_code),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_open_threshold_mv (cfg_open_threshold_mv),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_open_circuit      (out_open_circuit),
    .out_reading_valid     (out_reading_valid),
    .out_reading           (out_reading),
    .out_unit_code         (out_unit_code),
    .out_range_select      (out_range_select)
  );

endmodule
